// File: sv/htld_pkg.sv
// Shared types and constants for the Huffman tree load and decode unit.
// No dependencies.
package htld_pkg;

  localparam logic FN_TREE = 1'b0;
  localparam logic FN_CODE = 1'b1;

  localparam logic [7:0] CH_ONE  = 8'h31;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_READY   = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_SINGLE_LEAF = 2'd3
  } status_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data;
  } in_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       tree_ready;
    status_t    status;
  } out_t;

endpackage

// File: sv/htld_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module htld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/huffman_tree_load_and_decode_unit.sv
// Huffman tree load and decode unit: top level.
// Depends on htld_pkg and htld_ram (node store and open right-slot stack).
//
// Tree bytes (func 0) build a tree from its pre-order serialization and are taken one per
// cycle unless stalled; code characters (func 1) walk the tree and need an empty stage 2, since
// each step waits on a node read from the node memory before the walk register can advance.
// Every transfer in gives exactly one result transfer out, in order. A left child always sits
// at its parent's index plus one, so the node memory holds only the leaf flag, symbol and right
// link. No memory clearing runs after reset; the block takes items from the first cycle.
module huffman_tree_load_and_decode_unit #(
  parameter int MAX_NODES   = 512,
  parameter int STACK_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  htld_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_stall,
  output htld_pkg::out_t result
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
  localparam int NEED_W = LVL_W + 1;
  localparam int NODE_W = 1 + 8 + IDX_W;
  localparam int LEAF_B = NODE_W - 1;

  // builder state
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [LVL_W-1:0] lvl, lvl_next;
  logic [LVL_W-1:0] rc, rc_next;
  logic             await_sym, await_next;
  logic             complete, complete_next;
  logic             pend_left, pend_next;

  // walk state
  logic             walk_root;
  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] walk_right;
  logic [NODE_W-1:0] root_rec;

  // stage 1 decisions
  logic                 root_set;
  htld_pkg::status_t    s1_status;
  logic                 s1_wr_sym, s1_pop, s1_push, s1_rd, s1_bad;
  logic [IDX_W-1:0]     s1_addr, s1_n;
  logic [SP_W-1:0]      push_addr, pop_addr;

  // stage 2
  logic                 s2_valid, s2_go, s2_fire;
  htld_pkg::status_t    s2_status;
  logic                 s2_ready, s2_wr_sym, s2_pop, s2_rd, s2_bad;
  logic [IDX_W-1:0]     s2_addr, s2_n;
  logic [7:0]           s2_sym;

  logic                 acc;

  logic                 node_we;
  logic [IDX_W-1:0]     node_waddr;
  logic [NODE_W-1:0]    node_wdata, node_rdata;
  logic [IDX_W-1:0]     stack_rdata;

  htld_pkg::out_t       res_next;

  assign s2_go      = !result_valid || !result_stall;
  assign s2_fire    = s2_valid && s2_go;
  assign item_stall = s2_valid && (!s2_go || item.func == htld_pkg::FN_CODE);
  assign acc        = item_valid && !item_stall;

  always_comb begin
    logic             is_leaf;
    logic             dec;
    logic [NEED_W-1:0] need;
    logic [IDX_W-1:0] cur_right;
    logic [CNT_W-1:0] nxt;

    cnt_next      = cnt;
    lvl_next      = lvl;
    rc_next       = rc;
    await_next    = await_sym;
    complete_next = complete;
    pend_next     = pend_left;
    root_set      = 1'b0;
    s1_status     = htld_pkg::ST_OK;
    s1_wr_sym     = 1'b0;
    s1_pop        = 1'b0;
    s1_push       = 1'b0;
    s1_rd         = 1'b0;
    s1_bad        = 1'b0;
    s1_addr       = '0;
    s1_n          = '0;
    push_addr     = '0;
    pop_addr      = '0;
    is_leaf       = (item.data == htld_pkg::CH_ONE);
    dec           = 1'b0;
    need          = '0;
    cur_right     = walk_root ? root_rec[IDX_W-1:0] : walk_right;
    nxt           = '0;

    if (item.func == htld_pkg::FN_TREE) begin
      if (complete) begin
        cnt_next = '0; lvl_next = '0; rc_next = '0; await_next = 1'b0;
        complete_next = 1'b0; pend_next = 1'b0; root_set = 1'b1;
      end
      if (await_next) begin
        s1_wr_sym  = 1'b1;
        s1_addr    = IDX_W'(cnt_next - CNT_W'(1));
        await_next = 1'b0;
        if (lvl_next == '0) begin
          complete_next = 1'b1;
          root_set      = 1'b1;
        end
      end else if (cnt_next >= CNT_W'(MAX_NODES)) begin
        cnt_next = '0; lvl_next = '0; rc_next = '0; pend_next = 1'b0;
        s1_status = htld_pkg::ST_OVERFLOW; root_set = 1'b1;
      end else begin
        dec  = (cnt_next != '0) && (lvl_next != '0);
        need = NEED_W'(lvl_next) - NEED_W'(dec) + NEED_W'(2);
        if (!is_leaf && need > NEED_W'(STACK_DEPTH)) begin
          cnt_next = '0; lvl_next = '0; rc_next = '0; pend_next = 1'b0;
          s1_status = htld_pkg::ST_OVERFLOW; root_set = 1'b1;
        end else begin
          s1_n = IDX_W'(cnt_next);
          if (dec) begin
            lvl_next = lvl_next - LVL_W'(1);
            if (pend_next) begin
              pend_next = 1'b0;
            end else begin
              s1_pop   = 1'b1;
              rc_next  = rc_next - LVL_W'(1);
              pop_addr = SP_W'(rc_next);
            end
          end
          cnt_next = cnt_next + CNT_W'(1);
          if (is_leaf) begin
            await_next = 1'b1;
          end else begin
            s1_push   = 1'b1;
            push_addr = SP_W'(rc_next);
            rc_next   = rc_next + LVL_W'(1);
            lvl_next  = lvl_next + LVL_W'(2);
            pend_next = 1'b1;
          end
        end
      end
    end else begin
      if (!complete) begin
        s1_status = htld_pkg::ST_NOT_READY;
      end else if (root_rec[LEAF_B]) begin
        s1_status = htld_pkg::ST_SINGLE_LEAF;
      end else begin
        s1_rd = 1'b1;
        if (item.data == htld_pkg::CH_ZERO) begin
          nxt = CNT_W'(walk_idx) + CNT_W'(1);
        end else begin
          nxt = CNT_W'(cur_right);
        end
        s1_bad  = (nxt >= cnt);
        s1_addr = IDX_W'(nxt);
      end
    end
  end

  // builder and stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      lvl       <= '0;
      rc        <= '0;
      await_sym <= 1'b0;
      complete  <= 1'b0;
      pend_left <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      if (acc) begin
        cnt       <= cnt_next;
        lvl       <= lvl_next;
        rc        <= rc_next;
        await_sym <= await_next;
        complete  <= complete_next;
        pend_left <= pend_next;
        s2_valid  <= 1'b1;
      end else if (s2_go) begin
        s2_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s2_status <= s1_status;
      s2_ready  <= complete_next;
      s2_wr_sym <= s1_wr_sym;
      s2_pop    <= s1_pop;
      s2_rd     <= s1_rd;
      s2_bad    <= s1_bad;
      s2_addr   <= s1_addr;
      s2_n      <= s1_n;
      s2_sym    <= item.data;
    end
  end

  // walk position; a tree byte that resets the walk wins over a finishing code step
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_root <= 1'b1;
      walk_idx  <= '0;
    end else if (acc && root_set) begin
      walk_root <= 1'b1;
      walk_idx  <= '0;
    end else if (s2_fire && s2_rd) begin
      if (s2_bad || node_rdata[LEAF_B]) begin
        walk_root <= 1'b1;
        walk_idx  <= '0;
      end else begin
        walk_root <= 1'b0;
        walk_idx  <= s2_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && s2_rd) begin
      walk_right <= node_rdata[IDX_W-1:0];
    end
    if (node_we && node_waddr == '0) begin
      root_rec <= node_wdata;
    end
  end

  // node writes: leaf symbol, or right link into the popped parent
  assign node_we    = s2_fire && (s2_wr_sym || s2_pop);
  assign node_waddr = s2_pop ? stack_rdata : s2_addr;
  assign node_wdata = s2_pop ? {1'b0, 8'h00, s2_n} : {1'b1, s2_sym, {IDX_W{1'b0}}};

  htld_ram #(
    .WIDTH(NODE_W),
    .DEPTH(MAX_NODES)
  ) u_node_ram (
    .clk  (clk),
    .we   (node_we),
    .waddr(node_waddr),
    .wdata(node_wdata),
    .re   (acc && s1_rd),
    .raddr(s1_addr),
    .rdata(node_rdata)
  );

  // pop and push of one item may hit the same entry; the RAM returns the old word
  htld_ram #(
    .WIDTH(IDX_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (acc && s1_push),
    .waddr(push_addr),
    .wdata(s1_n),
    .re   (acc && s1_pop),
    .raddr(pop_addr),
    .rdata(stack_rdata)
  );

  always_comb begin
    res_next.symbol       = 8'h00;
    res_next.symbol_valid = 1'b0;
    res_next.tree_ready   = s2_ready;
    res_next.status       = s2_status;
    if (s2_rd && !s2_bad && node_rdata[LEAF_B]) begin
      res_next.symbol       = node_rdata[LEAF_B-1 -: 8];
      res_next.symbol_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      result <= res_next;
    end
  end

endmodule

// File: sv/htld_chk.sv
// Port-level checker for the Huffman tree load and decode unit, with its bind.
// Depends on htld_pkg and the top level's ports.
module htld_chk (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_stall,
  input htld_pkg::in_t  item,
  input logic           result_valid,
  input logic           result_stall,
  input htld_pkg::out_t result
);

  a_sym_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.symbol_valid |->
      result.status == htld_pkg::ST_OK && result.tree_ready)
    else $error("symbol with bad status or no tree");

  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.symbol_valid |-> result.symbol == 8'h00)
    else $error("symbol nonzero without symbol_valid");

  a_not_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == htld_pkg::ST_NOT_READY ||
                     result.status == htld_pkg::ST_OVERFLOW) |-> !result.tree_ready)
    else $error("tree_ready with not-ready or overflow status");

  a_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == htld_pkg::ST_SINGLE_LEAF |->
      result.tree_ready && !result.symbol_valid)
    else $error("single-leaf status inconsistent");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transfer changed");

endmodule

bind huffman_tree_load_and_decode_unit htld_chk u_htld_chk (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_stall  (item_stall),
  .item        (item),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

// File: sim/htld_checker.sv
// Checker for the Huffman tree load and decode unit: watches both channels, keeps its own
// tree builder and walker, and compares every result transfer with the oldest prediction.
// Depends on htld_pkg.
module htld_checker #(
  parameter int MAX_NODES   = 512,
  parameter int STACK_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_stall,
  input  htld_pkg::in_t  item,
  input  logic           result_valid,
  input  logic           result_stall,
  input  htld_pkg::out_t result,
  output int             fails,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        node_leaf  [MAX_NODES];
  logic [7:0]  node_sym   [MAX_NODES];
  int unsigned node_left  [MAX_NODES];
  int unsigned node_right [MAX_NODES];
  int unsigned slot_stack [STACK_DEPTH];
  int unsigned n_nodes;
  int unsigned depth;
  int unsigned cursor;
  bit          want_sym;
  bit          built;

  htld_pkg::out_t expected_results[$];
  htld_pkg::out_t want;
  htld_pkg::out_t got;
  int   fail_count;
  int   n_in;
  int   n_out;
  int   n_sym;
  int   n_overflow;
  int   n_not_ready;
  int   n_single;

  function automatic void restart_build();
    n_nodes  = 0;
    depth    = 0;
    want_sym = 1'b0;
    built    = 1'b0;
    cursor   = 0;
  endfunction

  // pop the newest open slot and hang node c there
  function automatic void link_child(int unsigned c);
    int unsigned slot;
    int unsigned par;
    if (depth == 0 || depth > STACK_DEPTH) return;
    depth--;
    slot = slot_stack[depth];
    par  = slot >> 1;
    if (par >= MAX_NODES) return;
    if ((slot & 1) != 0) node_right[par] = c;
    else node_left[par] = c;
  endfunction

  function automatic htld_pkg::status_t load_tree_byte(logic [7:0] b);
    int unsigned n;
    int unsigned need;
    if (built) restart_build();
    if (want_sym) begin
      if (n_nodes >= 1 && n_nodes <= MAX_NODES) node_sym[n_nodes - 1] = b;
      want_sym = 1'b0;
      if (depth == 0) begin
        built  = 1'b1;
        cursor = 0;
      end
      return htld_pkg::ST_OK;
    end
    if (n_nodes >= MAX_NODES) begin
      restart_build();
      return htld_pkg::ST_OVERFLOW;
    end
    n = n_nodes;
    if (b == htld_pkg::CH_ONE) begin
      if (n > 0) link_child(n);
      node_leaf[n]  = 1'b1;
      node_sym[n]   = 8'h00;
      node_left[n]  = 0;
      node_right[n] = 0;
      n_nodes       = n + 1;
      want_sym      = 1'b1;
      return htld_pkg::ST_OK;
    end
    need = depth - ((n > 0 && depth > 0) ? 1 : 0) + 2;
    if (need > STACK_DEPTH) begin
      restart_build();
      return htld_pkg::ST_OVERFLOW;
    end
    if (n > 0) link_child(n);
    node_leaf[n]      = 1'b0;
    node_sym[n]       = 8'h00;
    node_left[n]      = 0;
    node_right[n]     = 0;
    n_nodes           = n + 1;
    slot_stack[depth] = (n << 1) | 1;
    depth++;
    slot_stack[depth] = n << 1;
    depth++;
    return htld_pkg::ST_OK;
  endfunction

  function automatic htld_pkg::out_t predict_result(htld_pkg::in_t x);
    htld_pkg::out_t r;
    int unsigned    cur;
    int unsigned    nxt;
    r        = '0;
    r.status = htld_pkg::ST_OK;
    if (x.func == htld_pkg::FN_TREE) begin
      r.status = load_tree_byte(x.data);
    end else if (!built) begin
      r.status = htld_pkg::ST_NOT_READY;
    end else if (node_leaf[0]) begin
      r.status = htld_pkg::ST_SINGLE_LEAF;
    end else begin
      cur = (cursor < MAX_NODES) ? cursor : 0;
      nxt = (x.data == htld_pkg::CH_ZERO) ? node_left[cur] : node_right[cur];
      if (nxt >= MAX_NODES || nxt >= n_nodes) begin
        cursor = 0;
      end else if (node_leaf[nxt]) begin
        r.symbol       = node_sym[nxt];
        r.symbol_valid = 1'b1;
        cursor         = 0;
      end else begin
        cursor = nxt;
      end
    end
    r.tree_ready = built;
    return r;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic report();
    $display("Coverage: %0d items in, %0d results checked, %0d symbols decoded,", n_in, n_out,
             n_sym);
    $display("          %0d overflow, %0d tree-not-ready, %0d single-leaf responses",
             n_overflow, n_not_ready, n_single);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_build();
      expected_results.delete();
    end else begin
      if (item_valid && !item_stall) begin
        want = predict_result(item);
        expected_results.push_back(want);
        n_in++;
        if (want.symbol_valid) n_sym++;
        case (want.status)
          htld_pkg::ST_OVERFLOW:    n_overflow++;
          htld_pkg::ST_NOT_READY:   n_not_ready++;
          htld_pkg::ST_SINGLE_LEAF: n_single++;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        got = result;
        if (expected_results.size() == 0) begin
          log_failure($sformatf("unexpected result sym=%h v=%b rdy=%b st=%0d",
                                got.symbol, got.symbol_valid, got.tree_ready, got.status));
        end else begin
          want = expected_results.pop_front();
          n_out++;
          if (got.symbol !== want.symbol || got.symbol_valid !== want.symbol_valid ||
              got.tree_ready !== want.tree_ready || got.status !== want.status) begin
            log_failure($sformatf(
                "result %0d: expected sym=%h v=%b rdy=%b st=%0d, got sym=%h v=%b rdy=%b st=%0d",
                n_out, want.symbol, want.symbol_valid, want.tree_ready, want.status,
                got.symbol, got.symbol_valid, got.tree_ready, got.status));
          end
        end
      end
    end
    fails       <= fail_count;
    outstanding <= expected_results.size();
  end

endmodule

// File: sim/huffman_tree_load_and_decode_unit_tb.sv
// Testbench top for the Huffman tree load and decode unit: clock, reset, stimulus and verdict.
// Depends on htld_pkg, htld_checker and the unit itself.
module huffman_tree_load_and_decode_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES    = 512;
  localparam int STACK_DEPTH  = 256;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 64;
  localparam int LIMIT_CYCLES = 600_000;
  localparam int RANDOM_ITEMS = 300;

  logic           clk;
  logic           rst;
  logic           item_valid;
  logic           item_stall;
  htld_pkg::in_t  item;
  logic           result_valid;
  logic           result_stall;
  htld_pkg::out_t result;

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int sent;
  int rand_base;
  int fails;
  int outstanding;

  huffman_tree_load_and_decode_unit #(
    .MAX_NODES  (MAX_NODES),
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  htld_checker #(
    .MAX_NODES  (MAX_NODES),
    .STACK_DEPTH(STACK_DEPTH)
  ) chk (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall, or one long hold-off on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 85; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 85; end
      default: begin idle_pct = 21; stall_pct = 21; end
    endcase
  endtask

  task automatic send_item(input logic f, input logic [7:0] d);
    while ($urandom_range(0, 99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{func: f, data: d};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] inner_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == htld_pkg::CH_ONE) b = ~b;
    return b;
  endfunction

  // pre-order serialization of a random tree; noisy adds stray code chars and truncation
  task automatic send_tree(input int max_leaves, input bit noisy);
    int open_slots;
    int inner;
    int leaves_target;
    open_slots    = 1;
    inner         = 0;
    leaves_target = (max_leaves < 2) ? 1 : $urandom_range(2, max_leaves);
    while (open_slots > 0) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_item(htld_pkg::FN_CODE, 8'($urandom_range(0, 255)));
      if (noisy && $urandom_range(0, 199) == 0) return;
      if (inner < leaves_target - 1 && (inner == 0 || $urandom_range(0, 1) == 1)) begin
        send_item(htld_pkg::FN_TREE, inner_byte());
        inner++;
        open_slots++;
      end else begin
        send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
        send_item(htld_pkg::FN_TREE, 8'($urandom_range(0, 255)));
        open_slots--;
      end
    end
  endtask

  task automatic send_codes(input int cnt);
    repeat (cnt) begin
      if ($urandom_range(0, 29) == 0)
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      else
        send_item(htld_pkg::FN_CODE,
                  ($urandom_range(0, 1) == 1) ? htld_pkg::CH_ZERO : 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    hold_req    = 1'b0;
    sent        = 0;
    set_mode(0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // code chars with no tree
    send_item(htld_pkg::FN_CODE, htld_pkg::CH_ZERO);
    send_item(htld_pkg::FN_CODE, 8'hFF);
    // single-leaf tree
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, 8'h00);
    send_item(htld_pkg::FN_CODE, htld_pkg::CH_ZERO);
    send_item(htld_pkg::FN_CODE, 8'h80);
    // new tree replaces the held one; code char in the middle of the build
    send_item(htld_pkg::FN_TREE, 8'h00);
    send_item(htld_pkg::FN_CODE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, 8'hFF);
    send_item(htld_pkg::FN_TREE, 8'hFF);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ZERO);
    send_item(htld_pkg::FN_CODE, htld_pkg::CH_ZERO);
    send_item(htld_pkg::FN_CODE, 8'h00);
    send_item(htld_pkg::FN_CODE, htld_pkg::CH_ZERO);
    send_item(htld_pkg::FN_CODE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_CODE, 8'h7F);
    send_item(htld_pkg::FN_CODE, 8'h2F);
    // tree byte while the walk is mid-tree
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ZERO);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, 8'h55);
    send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
    send_item(htld_pkg::FN_TREE, 8'hAA);
    send_item(htld_pkg::FN_CODE, 8'hFF);
    wait_drained();

    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    send_tree(12, 1'b0);
    send_codes(60);
    wait_drained();

    // stack overflow: left-deep chain of internal nodes
    set_mode(3);
    repeat (STACK_DEPTH) send_item(htld_pkg::FN_TREE, inner_byte());
    // node overflow: stack kept near full until the node store runs out
    set_mode(1);
    repeat (STACK_DEPTH - 2) send_item(htld_pkg::FN_TREE, inner_byte());
    repeat ((MAX_NODES - STACK_DEPTH + 2) / 2) begin
      send_item(htld_pkg::FN_TREE, htld_pkg::CH_ONE);
      send_item(htld_pkg::FN_TREE, 8'($urandom_range(0, 255)));
      send_item(htld_pkg::FN_TREE, inner_byte());
    end
    send_item(htld_pkg::FN_TREE, 8'($urandom_range(0, 255)));
    wait_drained();

    rand_base = sent;
    while (sent - rand_base < RANDOM_ITEMS) begin
      set_mode(((sent - rand_base) / 75) % 4);
      if ($urandom_range(0, 19) == 0) send_tree(1, 1'b1);
      else send_tree(($urandom_range(0, 9) == 0) ? 64 : 10, 1'b1);
      send_codes($urandom_range(4, 40));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    chk.report();
    if (fails == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
